>>> src/kpd_pkg.sv
// Shared types and constants for the keypad scanner with hex digit entry.
// Used by kpd_ctrl, kpd_datapath and keypad_scan_digit_entry_top.
`timescale 1ns / 1ps

package kpd_pkg;

   localparam int DISPLAY_DIGITS = 8;
   localparam int POS_W          = 3;
   localparam int VAL_W          = 4;
   localparam int ROW_W          = 2;
   localparam int COL_W          = 4;

   // single-column patterns, bit3 is column 1
   localparam logic [COL_W-1:0] COL_PAT_1 = 4'b1000;
   localparam logic [COL_W-1:0] COL_PAT_2 = 4'b0100;
   localparam logic [COL_W-1:0] COL_PAT_3 = 4'b0010;
   localparam logic [COL_W-1:0] COL_PAT_4 = 4'b0001;

   localparam logic [POS_W-1:0] LAST_POS  = POS_W'(DISPLAY_DIGITS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BLANK,
      ST_DIGIT,
      ST_NOWR
   } ctrl_state_type;

   typedef enum logic [1:0] {
      EMIT_IDLE,
      EMIT_BLANK,
      EMIT_DIGIT
   } emit_kind_type;

   typedef struct packed {
      logic          load;
      logic          emit;
      emit_kind_type kind;
      logic          last;
   } ctrl_cmd_type;

   typedef struct packed {
      logic start_blank;  // incoming request blanks the display
      logic start_key;    // incoming request enters a key
      logic key_hit;      // latched: current request entered a key
      logic out_free;     // response register can take a result
      logic blank_done;   // blank counter at the final digit
      logic digit_last;   // one pending digit write left
   } ctrl_status_type;

   typedef struct packed {
      logic             hit;
      logic [VAL_W-1:0] key;
   } key_dec_type;

   function automatic key_dec_type decode_key(input logic [COL_W-1:0] cols,
                                              input logic [ROW_W-1:0] row);
      key_dec_type      res;
      logic [VAL_W-1:0] col_num;
      res     = '0;
      col_num = '0;
      case (cols)
         COL_PAT_1: begin res.hit = 1'b1; col_num = 4'd1; end
         COL_PAT_2: begin res.hit = 1'b1; col_num = 4'd2; end
         COL_PAT_3: begin res.hit = 1'b1; col_num = 4'd3; end
         COL_PAT_4: begin res.hit = 1'b1; col_num = 4'd4; end
         default:   begin res.hit = 1'b0; col_num = '0;   end
      endcase
      res.key = col_num + {row, 2'b00};
      return res;
   endfunction

endpackage

>>> src/kpd_ctrl.sv
// Controller FSM: sequences blank writes, digit writes and idle responses.
// Depends on kpd_pkg; drives kpd_datapath through ctrl_cmd_type.
`timescale 1ns / 1ps

module kpd_ctrl
   import kpd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.kind  = EMIT_IDLE;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (status.start_blank) begin
                  state_in = ST_BLANK;
               end else if (status.start_key) begin
                  state_in = ST_DIGIT;
               end else begin
                  state_in = ST_NOWR;
               end
            end
         end
         ST_BLANK: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = EMIT_BLANK;
               cmd.last = status.blank_done & ~status.key_hit;
               if (status.blank_done) begin
                  state_in = status.key_hit ? ST_DIGIT : ST_IDLE;
               end
            end
         end
         ST_DIGIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = EMIT_DIGIT;
               cmd.last = status.digit_last;
               if (status.digit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_NOWR: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = EMIT_IDLE;
               cmd.last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> src/kpd_datapath.sv
// Datapath: scan/lock state, entry store, write ordering and response register.
// Depends on kpd_pkg; commanded by kpd_ctrl.
`timescale 1ns / 1ps

module kpd_datapath
   import kpd_pkg::*;
#(
   parameter int DIGITS = 8
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                mode_switch,
   input  logic [COL_W-1:0]    column_bits,
   input  ctrl_cmd_type        cmd,
   output ctrl_status_type     status,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic                rsp_is_write,
   output logic [POS_W-1:0]    rsp_digit_pos,
   output logic [VAL_W-1:0]    rsp_digit_value,
   output logic                rsp_blank,
   output logic [ROW_W-1:0]    rsp_drive_row,
   output logic                rsp_last
);

   localparam int IDX_W = $clog2(DIGITS);
   localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(DIGITS - 1);

   // scan and lock state
   logic [ROW_W-1:0]  scan_row_ff, scan_row_in;
   logic [ROW_W-1:0]  held_row_ff, held_row_in;
   logic              locked_ff, locked_in;
   logic              mode_ff, mode_in;
   logic [ROW_W-1:0]  drive_ff, drive_in;

   // entry store
   logic [DIGITS-1:0] valid_ff, valid_in;
   logic [VAL_W-1:0]  value_ff [DIGITS];
   logic [VAL_W-1:0]  value_in [DIGITS];

   // write sequencing
   logic [DIGITS-1:0] pending_ff, pending_in;
   logic [POS_W-1:0]  blank_cnt_ff;
   logic              key_hit_ff;

   // response register
   logic              rsp_valid_ff;
   logic              rsp_is_write_ff;
   logic [POS_W-1:0]  rsp_pos_ff;
   logic [VAL_W-1:0]  rsp_value_ff;
   logic              rsp_blank_ff;
   logic [ROW_W-1:0]  rsp_drive_ff;
   logic              rsp_last_ff;

   key_dec_type       dec;
   logic              start_blank;
   logic              start_key;
   logic [DIGITS-1:0] valid_clr;

   logic [IDX_W-1:0]  sel_k;
   logic [IDX_W-1:0]  sel_e;
   logic [DIGITS-1:0] pending_rest;
   logic              out_free;

   // ---- request evaluation ----
   always_comb begin
      dec         = decode_key(column_bits, scan_row_ff);
      start_blank = ~locked_ff & mode_switch;
      start_key   = ~locked_ff & dec.hit;
      mode_in     = mode_ff ^ start_blank;
      valid_clr   = valid_ff & ~{DIGITS{start_blank}};

      valid_in = valid_clr;
      for (int i = 0; i < DIGITS; i++) begin
         value_in[i] = value_ff[i];
      end
      if (start_key) begin
         if (mode_in) begin
            for (int i = 0; i < DIGITS - 1; i++) begin
               valid_in[i] = valid_clr[i+1];
               value_in[i] = value_ff[i+1];
            end
            valid_in[DIGITS-1] = 1'b1;
            value_in[DIGITS-1] = dec.key;
         end else begin
            for (int i = 1; i < DIGITS; i++) begin
               valid_in[i] = valid_clr[i-1];
               value_in[i] = value_ff[i-1];
            end
            valid_in[0] = 1'b1;
            value_in[0] = dec.key;
         end
      end

      // pending mask in write order
      for (int k = 0; k < DIGITS; k++) begin
         pending_in[k] = start_key &
                         (mode_in ? valid_in[k] : valid_in[DIGITS-1-k]);
      end

      scan_row_in = scan_row_ff;
      held_row_in = held_row_ff;
      locked_in   = locked_ff;
      if (!locked_ff) begin
         scan_row_in = scan_row_ff + 1'b1;
         if (start_key) begin
            held_row_in = scan_row_ff;
            locked_in   = 1'b1;
         end
      end else if (!mode_switch && column_bits == '0) begin
         locked_in = 1'b0;
      end
      drive_in = locked_in ? held_row_in : scan_row_in;
   end

   // ---- next digit write: lowest pending slot ----
   always_comb begin
      sel_k = '0;
      for (int k = DIGITS - 1; k >= 0; k--) begin
         if (pending_ff[k]) begin
            sel_k = IDX_W'(k);
         end
      end
      sel_e        = mode_ff ? sel_k : TOP_IDX - sel_k;
      pending_rest = pending_ff;
      pending_rest[sel_k] = 1'b0;
   end

   assign out_free = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      status             = '0;
      status.start_blank = start_blank;
      status.start_key   = start_key;
      status.key_hit     = key_hit_ff;
      status.out_free    = out_free;
      status.blank_done  = (blank_cnt_ff == LAST_POS);
      status.digit_last  = (pending_rest == '0);
   end

   // ---- control state ----
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_row_ff  <= '0;
         held_row_ff  <= '0;
         locked_ff    <= 1'b0;
         mode_ff      <= 1'b0;
         drive_ff     <= '0;
         valid_ff     <= '0;
         pending_ff   <= '0;
         blank_cnt_ff <= '0;
         key_hit_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            scan_row_ff  <= scan_row_in;
            held_row_ff  <= held_row_in;
            locked_ff    <= locked_in;
            mode_ff      <= mode_in;
            drive_ff     <= drive_in;
            valid_ff     <= valid_in;
            pending_ff   <= pending_in;
            blank_cnt_ff <= '0;
            key_hit_ff   <= start_key;
         end else if (cmd.emit) begin
            if (cmd.kind == EMIT_BLANK) begin
               blank_cnt_ff <= blank_cnt_ff + 1'b1;
            end
            if (cmd.kind == EMIT_DIGIT) begin
               pending_ff <= pending_rest;
            end
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---- payload ----
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int i = 0; i < DIGITS; i++) begin
            value_ff[i] <= value_in[i];
         end
      end
      if (cmd.emit) begin
         rsp_drive_ff <= drive_ff;
         rsp_last_ff  <= cmd.last;
         case (cmd.kind)
            EMIT_BLANK: begin
               rsp_is_write_ff <= 1'b1;
               rsp_pos_ff      <= blank_cnt_ff;
               rsp_value_ff    <= '0;
               rsp_blank_ff    <= 1'b1;
            end
            EMIT_DIGIT: begin
               rsp_is_write_ff <= 1'b1;
               rsp_pos_ff      <= LAST_POS - POS_W'(sel_e);
               rsp_value_ff    <= value_ff[sel_e];
               rsp_blank_ff    <= 1'b0;
            end
            default: begin
               rsp_is_write_ff <= 1'b0;
               rsp_pos_ff      <= '0;
               rsp_value_ff    <= '0;
               rsp_blank_ff    <= 1'b0;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_is_write    = rsp_is_write_ff;
   assign rsp_digit_pos   = rsp_pos_ff;
   assign rsp_digit_value = rsp_value_ff;
   assign rsp_blank       = rsp_blank_ff;
   assign rsp_drive_row   = rsp_drive_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

>>> src/keypad_scan_digit_entry_top.sv
// Top level of the keypad scanner with hex digit entry display.
// Depends on kpd_pkg, kpd_ctrl and kpd_datapath.
//
// Usage:
//   One request per keypad poll tick on req_*: the mode switch and the four
//   column bits read under the row given by the previous response.
//   Responses on rsp_*: display digit writes (tuser = 1) or a single idle
//   response (tuser = 0); tlast marks the final response of a request.
//   Every response of a request carries the row to drive before next tick.
// Timing:
//   A request is taken while the controller is idle; its first response is
//   registered after the controller leaves idle, and then one per cycle while
//   rsp_tready is high. A request has 1 to 9 responses, and the block takes
//   no new request until the FSM walking the writes has registered the last.
// Stall:
//   The response register holds while rsp_tready is low and the sequence
//   pauses; req_tready stays low until the final response is registered.
// Reset:
//   Synchronous, active high: unlocked, row 0, insert at entry 0, store empty,
//   no response pending.
`timescale 1ns / 1ps

module keypad_scan_digit_entry_top
   import kpd_pkg::*;
#(
   parameter int DIGITS = 8
)
(
   input  logic        clock,
   input  logic        reset,
   // request: [0] mode_switch, [4:1] column_bits, [7:5] zero
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   // response: [2:0] digit_pos, [6:3] digit_value, [7] blank,
   //           [9:8] drive_row, [15:10] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,
   // response tuser: [0] is_write
   output logic        rsp_tuser,
   output logic        rsp_tlast
);

   ctrl_cmd_type     cmd;
   ctrl_status_type  status;

   logic [POS_W-1:0] digit_pos;
   logic [VAL_W-1:0] digit_value;
   logic             blank;
   logic [ROW_W-1:0] drive_row;

   kpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   kpd_datapath #(
      .DIGITS (DIGITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .mode_switch     (req_tdata[0]),
      .column_bits     (req_tdata[4:1]),
      .cmd             (cmd),
      .status          (status),
      .rsp_ready       (rsp_tready),
      .rsp_valid       (rsp_tvalid),
      .rsp_is_write    (rsp_tuser),
      .rsp_digit_pos   (digit_pos),
      .rsp_digit_value (digit_value),
      .rsp_blank       (blank),
      .rsp_drive_row   (drive_row),
      .rsp_last        (rsp_tlast)
   );

   assign rsp_tdata = {6'b0, drive_row, blank, digit_value, digit_pos};

endmodule

>>> tb/tb_top.sv
// Self-checking bench for keypad_scan_digit_entry_top: poll ticks in, display writes out.
// Depends on kpd_pkg and the RTL under src/; needs nothing else to run.
`timescale 1ns / 1ps

module tb_top;
   import kpd_pkg::*;

   localparam int ENTRIES    = 8;
   localparam int IDLE_LIMIT = 2000;  // cycles with no handshake before giving up
   localparam int LONG_HOLD  = 120;   // one long sink stall, fills the block
   localparam int HOLD_AT    = 60;    // response count that triggers it
   localparam int TAIL       = 20;    // settle cycles after the last response

   // one display write (or idle marker) as seen on rsp_*
   typedef struct packed {
      logic             is_write;
      logic [POS_W-1:0] pos;
      logic [VAL_W-1:0] value;
      logic             blank;
      logic [ROW_W-1:0] row;
      logic             last;
   } digit_write_t;

   // one poll tick waiting to go out on req_*
   typedef struct {
      logic             sw;
      logic [COL_W-1:0] cols;
      int               gap;    // idle cycles before offering
      bit               drain;  // hold until every pending write is back
   } poll_tick_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   poll_tick_t   tick_q [$];
   digit_write_t expected_writes_q [$];

   // scanner state as the block should hold it
   logic [ROW_W-1:0]   scan_row   = '0;
   logic [ROW_W-1:0]   held_row   = '0;
   logic               locked     = 1'b0;
   logic               shift_left = 1'b0;
   logic [ENTRIES-1:0] entry_valid = '0;
   logic [VAL_W-1:0]   entry_val [ENTRIES];

   int mismatch_count = 0;
   int rsp_count      = 0;
   int idle_cycles    = 0;

   always #1 clock = ~clock;

   keypad_scan_digit_entry_top #(.DIGITS(ENTRIES)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // ---------------------------------------------------------------------
   // Scanner prediction: one accepted poll tick -> its display writes.
   // Unlocked: switch toggles direction and blanks all digits, then the
   // scanned row is decoded; a key shifts into the store and locks the
   // scanner on that row. Locked: wait for switch off and columns zero.
   // ---------------------------------------------------------------------
   task automatic apply_poll_tick(input logic sw, input logic [COL_W-1:0] cols);
      digit_write_t     wr [DISPLAY_DIGITS + 1];
      int               n;
      logic [ROW_W-1:0] row;
      logic             hit;
      logic [VAL_W-1:0] key;
      logic [ROW_W-1:0] drive;
      n   = 0;
      hit = 1'b0;
      key = '0;
      if (!locked) begin
         if (sw) begin
            shift_left = ~shift_left;
            for (int i = 0; i < DISPLAY_DIGITS; i++) begin
               wr[n] = '{1'b1, POS_W'(i), '0, 1'b1, '0, 1'b0};
               n++;
            end
            entry_valid = '0;
            for (int i = 0; i < ENTRIES; i++) entry_val[i] = '0;
         end
         row = scan_row;
         scan_row = scan_row + 1'b1;
         // exactly one column bit makes a key; bit3 is column 1
         case (cols)
            COL_PAT_1: begin hit = 1'b1; key = 4'd1; end
            COL_PAT_2: begin hit = 1'b1; key = 4'd2; end
            COL_PAT_3: begin hit = 1'b1; key = 4'd3; end
            COL_PAT_4: begin hit = 1'b1; key = 4'd4; end
            default:   hit = 1'b0;
         endcase
         if (hit) begin
            key = key + {row, 2'b00};  // row 3 column 4 wraps to 0
            if (shift_left) begin
               // key enters at the top entry, writes go entry 0 upward
               for (int i = 0; i < ENTRIES - 1; i++) begin
                  entry_valid[i] = entry_valid[i + 1];
                  entry_val[i]   = entry_val[i + 1];
               end
               entry_valid[ENTRIES - 1] = 1'b1;
               entry_val[ENTRIES - 1]   = key;
               for (int i = 0; i < ENTRIES; i++)
                  if (entry_valid[i]) begin
                     wr[n] = '{1'b1, LAST_POS - POS_W'(i), entry_val[i], 1'b0, '0, 1'b0};
                     n++;
                  end
            end else begin
               // key enters at entry 0, writes go from the top entry down
               for (int i = ENTRIES - 1; i > 0; i--) begin
                  entry_valid[i] = entry_valid[i - 1];
                  entry_val[i]   = entry_val[i - 1];
               end
               entry_valid[0] = 1'b1;
               entry_val[0]   = key;
               for (int i = ENTRIES - 1; i >= 0; i--)
                  if (entry_valid[i]) begin
                     wr[n] = '{1'b1, LAST_POS - POS_W'(i), entry_val[i], 1'b0, '0, 1'b0};
                     n++;
                  end
            end
            held_row = row;
            locked   = 1'b1;
         end
      end else if (!sw && cols == '0) begin
         locked = 1'b0;
      end
      drive = locked ? held_row : scan_row;
      if (n == 0) begin
         wr[0] = '0;  // idle response
         n = 1;
      end
      for (int i = 0; i < n; i++) begin
         wr[i].row  = drive;
         wr[i].last = (i == n - 1);
         expected_writes_q.push_back(wr[i]);
      end
   endtask

   // queue one tick; gaps drop to zero in every third block of 16 for bursts
   task automatic add_tick(input logic sw, input logic [COL_W-1:0] cols, input bit drain);
      poll_tick_t t;
      t.sw    = sw;
      t.cols  = cols;
      t.drain = drain;
      t.gap   = ((tick_q.size() / 16) % 3 == 2) ? 0 : $urandom_range(0, 8);
      tick_q.push_back(t);
   endtask

   // ---------------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------------
   initial begin
      int  n_random;
      int  n_base;
      int  pick;
      bit  mid_drained;
      bit  drain;
      for (int i = 0; i < ENTRIES; i++) entry_val[i] = '0;

      // directed: no-key patterns, each column, locked ticks, unlock,
      // toggle, held switch, switch with key, both shift directions
      add_tick(1'b0, 4'b0000, 1'b0);  // nothing pressed, row advances
      add_tick(1'b0, 4'b1111, 1'b0);  // all columns: no key
      add_tick(1'b0, 4'b1010, 1'b0);  // two columns: no key
      add_tick(1'b0, COL_PAT_1, 1'b0);  // row 3 column 1, locks
      add_tick(1'b1, COL_PAT_4, 1'b0);  // locked: switch ignored
      add_tick(1'b0, COL_PAT_2, 1'b0);  // locked: columns still up
      add_tick(1'b0, 4'b0000, 1'b0);  // release unlocks
      add_tick(1'b1, 4'b0000, 1'b0);  // toggle and blank
      add_tick(1'b1, 4'b0000, 1'b0);  // switch held: toggles again
      add_tick(1'b1, COL_PAT_3, 1'b0);  // blank plus key, nine writes
      add_tick(1'b0, 4'b0000, 1'b0);
      add_tick(1'b0, COL_PAT_2, 1'b0);
      add_tick(1'b0, 4'b0000, 1'b0);
      add_tick(1'b0, COL_PAT_1, 1'b0);
      add_tick(1'b0, 4'b0000, 1'b0);
      add_tick(1'b1, 4'b0000, 1'b0);  // back to inserting at entry 0
      add_tick(1'b0, COL_PAT_4, 1'b0);
      add_tick(1'b0, 4'b0000, 1'b0);
      add_tick(1'b0, COL_PAT_3, 1'b0);
      add_tick(1'b0, 4'b0000, 1'b0);
      add_tick(1'b0, 4'b0111, 1'b0);

      // random: mostly press / release sequences, some switch ticks and noise
      n_base      = tick_q.size();
      mid_drained = 1'b0;
      while (tick_q.size() < 130) begin
         n_random = tick_q.size() - n_base;
         drain = (n_random == 0) || (!mid_drained && n_random >= 54);
         if (drain && n_random != 0) mid_drained = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            add_tick(1'b0, COL_W'(1 << $urandom_range(0, 3)), drain);
            // chatter while locked, columns nonzero so it stays locked
            repeat ($urandom_range(0, 2))
               add_tick(1'($urandom_range(0, 1)), COL_W'($urandom_range(1, 15)), 1'b0);
            add_tick(1'b0, 4'b0000, 1'b0);
         end else if (pick < 72) begin
            add_tick(1'b1, COL_W'($urandom_range(0, 15)), drain);
         end else begin
            add_tick(1'($urandom_range(0, 1)), COL_W'($urandom_range(0, 15)), drain);
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (tick_q.size() != 0 || req_tvalid || expected_writes_q.size() != 0)
         @(posedge clock);
      repeat (TAIL) @(posedge clock);
      if (mismatch_count == 0)
         $display("keypad_scan_digit_entry_top: match");
      else
         $display("keypad_scan_digit_entry_top: mismatch");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Request driver: predicts on acceptance, then offers the next tick
   // after its gap. A drain tick waits until every write is back.
   // ---------------------------------------------------------------------
   int         gap_left = 0;
   bit         gap_loaded = 1'b0;
   poll_tick_t cur_tick;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            apply_poll_tick(cur_tick.sw, cur_tick.cols);
         if (req_tvalid && !req_tready) begin
            // request still pending, hold it
         end else if (tick_q.size() == 0) begin
            req_tvalid <= 1'b0;
         end else begin
            if (!gap_loaded) begin
               gap_left   = tick_q[0].gap;
               gap_loaded = 1'b1;
            end
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (tick_q[0].drain && expected_writes_q.size() != 0) begin
               req_tvalid <= 1'b0;
            end else begin
               cur_tick   = tick_q.pop_front();
               gap_loaded = 1'b0;
               req_tdata  <= {3'b000, cur_tick.cols, cur_tick.sw};
               req_tvalid <= 1'b1;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response monitor: checks against the oldest expected write, then
   // draws its stall; one long hold once enough writes have come.
   // ---------------------------------------------------------------------
   int           stall_left = 0;
   int           hold_left  = 0;
   bit           hold_done  = 1'b0;
   digit_write_t got;
   digit_write_t want;
   bit           bad;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tuser, rsp_tdata[2:0], rsp_tdata[6:3], rsp_tdata[7],
                    rsp_tdata[9:8], rsp_tlast};
            bad = 1'b1;
            want = '0;
            if (expected_writes_q.size() != 0) begin
               want = expected_writes_q.pop_front();
               bad  = (got != want);
            end
            if (bad) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("write %0d: exp wr=%0d pos=%0d val=%h blank=%0d row=%0d last=%0d%s",
                           rsp_count, want.is_write, want.pos, want.value, want.blank,
                           want.row, want.last,
                           (expected_writes_q.size() == 0 && want == '0) ? " (none)" : "");
               if (mismatch_count <= 10)
                  $display("          got wr=%0d pos=%0d val=%h blank=%0d row=%0d last=%0d",
                           got.is_write, got.pos, got.value, got.blank, got.row, got.last);
            end
            rsp_count++;
            stall_left = ((rsp_count / 32) % 3 == 1) ? 0 : $urandom_range(0, 8);
            if (!hold_done && rsp_count >= HOLD_AT) begin
               hold_left = LONG_HOLD;
               hold_done = 1'b1;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog: any handshake resets the count
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("keypad_scan_digit_entry_top: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
